// ===== hw/rtl/class_aware_box_nms_defines.svh =====
// Assertion macros for the box suppression block
`ifndef CLASS_AWARE_BOX_NMS_DEFINES_SVH
`define CLASS_AWARE_BOX_NMS_DEFINES_SVH
`define CBN_ASSERT_IMP(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("violation");
`define CBN_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("violation");
`endif

// ===== hw/rtl/cbn_pkg.sv =====
// Shared types and constants for the box suppression block
package cbn_pkg;
    localparam int MAX_BOXES = 64;
    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam logic [16:0] THR_RESET = 17'd32768;

    typedef struct packed {
        logic [15:0] x1;
        logic [15:0] y1;
        logic [15:0] x2;
        logic [15:0] y2;
        logic [15:0] score;
        logic [7:0]  cls;
    } box_t;

    typedef struct packed {
        box_t box;
        logic last;
        logic drop;
    } qent_t;

    typedef struct packed {
        box_t box;
        logic last;
        logic ovf;
    } res_t;

    typedef enum logic [2:0] {
        ST_LOAD, ST_PRE, ST_SEL, ST_SELW, ST_EMIT, ST_CMP, ST_CMPW, ST_CHK
    } state_t;
endpackage

// ===== hw/rtl/cbn_front.sv =====
// Input front end: takes items into a short queue, marks dropped boxes
module cbn_front import cbn_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  box_t  in_box,
    input  logic  in_last,
    output logic  q_valid,
    input  logic  q_pop,
    output qent_t q_data
);
    qent_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic wr_reg, rd_reg;
    logic [CNT_W-1:0] seen_reg;
    logic push;
    qent_t ent;

    assign in_stall = (cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = q_reg[rd_reg];
    always_comb
    begin
        ent.box = in_box;
        ent.last = in_last;
        ent.drop = (seen_reg == CNT_W'(MAX_BOXES));
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= ent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            seen_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_reg <= !wr_reg;
                if (in_last)
                    seen_reg <= '0;
                else if (!ent.drop)
                    seen_reg <= seen_reg + 1'b1;
            end
            if (q_pop)
                rd_reg <= !rd_reg;
        end
    end
endmodule

// ===== hw/rtl/cbn_iou.sv =====
// Multi-cycle IoU test unit for one box pair
module cbn_iou import cbn_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  box_t        a,
    input  box_t        b,
    input  logic [16:0] thr,
    output logic        done,
    output logic        hit
);
    logic signed [17:0] w_reg, h_reg, aw_reg, ah_reg, bw_reg, bh_reg;
    logic signed [35:0] in_reg, aa_reg, ba_reg;
    logic signed [37:0] un_reg;
    logic signed [53:0] lhs_reg;
    logic [36:0] un_lo_reg;
    logic [16:0] thr_reg;
    logic [53:0] p0_reg, p1_reg;
    logic [4:0] ph_reg;
    logic touch_reg;
    logic signed [17:0] ix1, iy1, ix2, iy2, w, h;
    logic [35:0] m0;
    logic [34:0] m1;

    always_comb
    begin
        ix1 = $signed({2'b0, (a.x1 > b.x1) ? a.x1 : b.x1});
        iy1 = $signed({2'b0, (a.y1 > b.y1) ? a.y1 : b.y1});
        ix2 = $signed({2'b0, (a.x2 < b.x2) ? a.x2 : b.x2});
        iy2 = $signed({2'b0, (a.y2 < b.y2) ? a.y2 : b.y2});
        w = (ix2 > ix1) ? ix2 - ix1 : 18'sd0;
        h = (iy2 > iy1) ? iy2 - iy1 : 18'sd0;
    end

    assign m0 = thr_reg * un_reg[18:0];
    assign m1 = thr_reg * un_lo_reg[36:19];

    assign done = ph_reg[4];
    assign hit = touch_reg && (un_reg > 38'sd0) &&
                 ($signed({2'b0, lhs_reg}) > $signed({1'b0, p0_reg + p1_reg}));

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            w_reg <= w;
            h_reg <= h;
            aw_reg <= $signed({2'b0, a.x2}) - $signed({2'b0, a.x1});
            ah_reg <= $signed({2'b0, a.y2}) - $signed({2'b0, a.y1});
            bw_reg <= $signed({2'b0, b.x2}) - $signed({2'b0, b.x1});
            bh_reg <= $signed({2'b0, b.y2}) - $signed({2'b0, b.y1});
            touch_reg <= !(b.x1 > a.x2 || a.x1 > b.x2 || b.y1 > a.y2 || a.y1 > b.y2);
            thr_reg <= thr;
        end
        if (ph_reg[0])
        begin
            in_reg <= w_reg * h_reg;
            aa_reg <= aw_reg * ah_reg;
            ba_reg <= bw_reg * bh_reg;
        end
        if (ph_reg[1])
            un_reg <= 38'(aa_reg) + 38'(ba_reg) - 38'(in_reg);
        if (ph_reg[2])
        begin
            un_lo_reg <= un_reg[36:0];
            lhs_reg <= 54'(in_reg) <<< 16;
            p0_reg <= 54'(m0);
        end
        if (ph_reg[3])
            p1_reg <= {m1, 19'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ph_reg <= '0;
        else
            ph_reg <= {ph_reg[3:0], start};
    end
endmodule

// ===== hw/rtl/cbn_back.sv =====
// Back end: stores a batch, selects by score, suppresses and emits items
module cbn_back import cbn_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [16:0] thr,
    input  logic        q_valid,
    output logic        q_pop,
    input  qent_t       q_data,
    output logic        out_valid,
    input  logic        out_stall,
    output res_t        out_data
);
    box_t mem [MAX_BOXES];
    logic [MAX_BOXES-1:0] done_reg, done_next;
    state_t st_reg, st_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] best_reg, best_next, rd_addr;
    logic [15:0] bs_reg, bs_next;
    logic bf_reg, bf_next, ovf_reg, ovf_next, left_reg, left_next;
    box_t rd_reg, a_reg;
    logic ov_reg, ov_next, iou_start, iou_done, iou_hit, wr, load_a;
    res_t od_reg, od_next;
    logic [IDX_W-1:0] kk;

    assign kk = k_reg[IDX_W-1:0];
    assign out_valid = ov_reg;
    assign out_data = od_reg;

    cbn_iou u_iou (
        .clk(clk), .rst_n(rst_n), .start(iou_start), .a(a_reg), .b(rd_reg),
        .thr(thr), .done(iou_done), .hit(iou_hit)
    );

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[n_reg[IDX_W-1:0]] <= q_data.box;
        rd_reg <= mem[rd_addr];
        if (load_a)
            a_reg <= rd_reg;
    end

    always_comb
    begin
        st_next = st_reg;
        n_next = n_reg;
        k_next = k_reg;
        best_next = best_reg;
        bs_next = bs_reg;
        bf_next = bf_reg;
        ovf_next = ovf_reg;
        left_next = left_reg;
        done_next = done_reg;
        ov_next = ov_reg && out_stall;
        od_next = od_reg;
        q_pop = 1'b0;
        wr = 1'b0;
        load_a = 1'b0;
        iou_start = 1'b0;
        rd_addr = kk;
        unique case (st_reg)
            ST_LOAD:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    wr = !q_data.drop;
                    if (!q_data.drop)
                        n_next = n_reg + 1'b1;
                    ovf_next = ovf_reg || q_data.drop;
                    if (q_data.last)
                    begin
                        st_next = ST_PRE;
                        k_next = '0;
                        bf_next = 1'b0;
                        done_next = '0;
                    end
                end
            end
            ST_PRE:
            begin
                rd_addr = '0;
                st_next = ST_SEL;
            end
            ST_SEL:
            begin
                if (k_reg == n_reg)
                begin
                    if (!bf_reg)
                    begin
                        st_next = ST_LOAD;
                        n_next = '0;
                        ovf_next = 1'b0;
                    end
                    else
                    begin
                        rd_addr = best_reg;
                        st_next = ST_SELW;
                    end
                end
                else
                begin
                    if (!done_reg[kk] && (!bf_reg || rd_reg.score > bs_reg))
                    begin
                        bf_next = 1'b1;
                        best_next = kk;
                        bs_next = rd_reg.score;
                    end
                    k_next = k_reg + 1'b1;
                    rd_addr = kk + 1'b1;
                end
            end
            ST_SELW:
            begin
                load_a = 1'b1;
                done_next[best_reg] = 1'b1;
                st_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                left_next = 1'b0;
                k_next = '0;
                st_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (k_reg == n_reg)
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        ov_next = 1'b1;
                        od_next.box = a_reg;
                        od_next.ovf = ovf_reg;
                        od_next.last = !left_reg;
                        if (!left_reg)
                        begin
                            n_next = '0;
                            ovf_next = 1'b0;
                            st_next = ST_LOAD;
                        end
                        else
                        begin
                            k_next = '0;
                            bf_next = 1'b0;
                            rd_addr = '0;
                            st_next = ST_SEL;
                        end
                    end
                end
                else
                    st_next = ST_CMPW;
            end
            ST_CMPW:
            begin
                if (!done_reg[kk] && rd_reg.cls != a_reg.cls)
                    left_next = 1'b1;
                if (done_reg[kk] || rd_reg.cls != a_reg.cls)
                    k_next = k_reg + 1'b1;
                else
                    iou_start = 1'b1;
                st_next = (done_reg[kk] || rd_reg.cls != a_reg.cls) ? ST_CMP : ST_CHK;
            end
            ST_CHK:
            begin
                if (iou_done)
                begin
                    if (iou_hit)
                        done_next[kk] = 1'b1;
                    else
                        left_next = 1'b1;
                    k_next = k_reg + 1'b1;
                    st_next = ST_CMP;
                end
            end
            default: st_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        bs_reg <= bs_next;
        od_reg <= od_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_LOAD;
            n_reg <= '0;
            k_reg <= '0;
            bf_reg <= 1'b0;
            ovf_reg <= 1'b0;
            left_reg <= 1'b0;
            done_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            n_reg <= n_next;
            k_reg <= k_next;
            bf_reg <= bf_next;
            ovf_reg <= ovf_next;
            left_reg <= left_next;
            done_reg <= done_next;
            ov_reg <= ov_next;
        end
    end
endmodule

// ===== hw/rtl/class_aware_box_nms.sv =====
// Top level of the class-aware greedy box suppression block
// channel | signals                          | direction
// in      | in_valid/in_stall, box_*         | into block
// out     | out_valid/out_stall, kept_*      | out of block
// cfg     | cfg_we/cfg_wdata (threshold)     | into block
// Loading takes one box per cycle while the back end is in its load state and the
// queue holds a box. Each kept box then costs a selection sweep over the stored
// boxes, a fetch of the selected box, and a compare sweep over the stored boxes
// with an IoU test for each unsuppressed box of the same class.
// Reset clears control state; the threshold returns to 0.5.
// A kept item waits for the output register; a two-entry queue decouples input.
module class_aware_box_nms import cbn_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] box_x1,
    input  logic [15:0] box_y1,
    input  logic [15:0] box_x2,
    input  logic [15:0] box_y2,
    input  logic [15:0] box_score,
    input  logic [7:0]  box_class,
    input  logic        last_box,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] kept_x1,
    output logic [15:0] kept_y1,
    output logic [15:0] kept_x2,
    output logic [15:0] kept_y2,
    output logic [15:0] kept_score,
    output logic [7:0]  kept_class,
    output logic        last_kept,
    output logic        overflowed
);
    logic [16:0] thr_reg;
    box_t ib;
    qent_t qd;
    logic qv, qp;
    res_t r;

    assign ib = '{x1: box_x1, y1: box_y1, x2: box_x2, y2: box_y2,
                  score: box_score, cls: box_class};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    cbn_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_box(ib), .in_last(last_box), .q_valid(qv), .q_pop(qp), .q_data(qd)
    );

    cbn_back u_back (
        .clk(clk), .rst_n(rst_n), .thr(thr_reg), .q_valid(qv), .q_pop(qp),
        .q_data(qd), .out_valid(out_valid), .out_stall(out_stall), .out_data(r)
    );

    assign kept_x1 = r.box.x1;
    assign kept_y1 = r.box.y1;
    assign kept_x2 = r.box.x2;
    assign kept_y2 = r.box.y2;
    assign kept_score = r.box.score;
    assign kept_class = r.box.cls;
    assign last_kept = r.last;
    assign overflowed = r.ovf;
endmodule

// ===== hw/rtl/cbn_checker.sv =====
// Port-level checker for the box suppression block, with its bind
`include "class_aware_box_nms_defines.svh"
module cbn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        last_kept,
    input logic        overflowed,
    input logic [15:0] kept_score
);
    `CBN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kept_score))
    `CBN_ASSERT_NEXT(a_score_order, out_valid && !out_stall && !last_kept,
        !out_valid || kept_score <= $past(kept_score))
    `CBN_ASSERT_NEXT(a_ovf_steady, out_valid && !out_stall && !last_kept,
        !out_valid || overflowed == $past(overflowed))
endmodule

bind class_aware_box_nms cbn_checker u_cbn_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .last_kept(last_kept), .overflowed(overflowed), .kept_score(kept_score)
);
